// File: rtl/rwmc_pkg.sv
// shared types, register indexes and constants of the window mean/covariance block
package rwmc_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_WIN_LEFT   = 8'd0;
    localparam logic [7:0] REG_WIN_TOP    = 8'd1;
    localparam logic [7:0] REG_WIN_WIDTH  = 8'd2;
    localparam logic [7:0] REG_WIN_HEIGHT = 8'd3;

    // reset values of the window registers
    localparam logic [11:0] WIN_LEFT_RST   = 12'd515;
    localparam logic [11:0] WIN_TOP_RST    = 12'd189;
    localparam logic [8:0]  WIN_WIDTH_RST  = 9'd9;
    localparam logic [8:0]  WIN_HEIGHT_RST = 9'd4;

    // result limits
    localparam logic [15:0] MEAN_MAX = 16'd65280;
    localparam logic [22:0] COV_MAX  = 23'd4161600;

    // datapath widths
    localparam int CNT_W = 17;
    localparam int SUM_W = 24;
    localparam int PRD_W = 32;
    localparam int NN_W  = 34;   // count squared
    localparam int DVD_W = 57;   // 49-bit numerator magnitude with 8 fraction bits
    localparam int MUL_W = 56;   // 32 x 24 shared multiplier

    typedef logic [1:0] chan_t;  // 0 blue, 1 green, 2 red

    // channel pair of cross-product k: bb, bg, br, gg, gr, rr
    function automatic chan_t pair_x(input logic [2:0] k);
        chan_t c;
        unique case (k)
            3'd0, 3'd1, 3'd2: c = 2'd0;
            3'd3, 3'd4:       c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic chan_t pair_y(input logic [2:0] k);
        chan_t c;
        unique case (k)
            3'd0:       c = 2'd0;
            3'd1, 3'd3: c = 2'd1;
            default:    c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/rgb_window_mean_covariance.sv
// windowed three-channel mean and population covariance over a pixel stream
// a pixel outside the window, unless it ends the frame, leaves the block idle; one inside
// runs six cross products through the shared 32x24 multiplier (multiply, then accumulate)
// a frame end adds 9 divisions of 57 steps each in the shared restoring divider,
// plus multiplier steps; one word in flight at a time
// aresetn (synchronous, active low) restores the window registers and clears all sums
module rgb_window_mean_covariance
    import rwmc_pkg::*;
#(
    parameter int MAX_WIN_SIDE = 256,
    parameter int COORD_BITS   = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [11:0]  cfg_data,
    // pixel input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // col_pos, row_pos, blue, green, red
    input  logic         s_tlast,   // frame_end
    // result output
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [183:0] m_tdata,   // mean_blue, mean_green, mean_red, cov_bb, cov_bg,
                                    // cov_br, cov_gg, cov_gr, cov_rr, zero pad
    output logic         m_tuser    // window_empty
);

    localparam int CW = 18;
    localparam int unsigned CMASK_I = (1 << COORD_BITS) - 1;
    localparam logic [CW-1:0] CMASK = CW'(CMASK_I);
    localparam logic [CW-1:0] SIDE_MAX = CW'(MAX_WIN_SIDE);
    localparam logic [5:0] DIV_LAST = 6'(DVD_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PMUL, ST_PACC, ST_FIN, ST_DEN, ST_MLD,
        ST_CX, ST_CY, ST_CSUB, ST_DIV, ST_DST, ST_OUT
    } state_t;

    state_t state_reg;

    logic [11:0] win_left_reg, win_top_reg;
    logic [8:0]  win_width_reg, win_height_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] ch_sum_reg [0:2];
    logic [PRD_W-1:0] sxy_reg [0:5];
    logic [7:0]       samp_reg [0:2];
    logic             last_reg;
    logic [2:0]       k_reg;
    logic [1:0]       j_reg;
    logic             cov_mode_reg;
    logic             neg_reg;

    logic [MUL_W-1:0] mul_reg;
    logic [48:0]      p1_reg;
    logic [NN_W-1:0]  nn_reg;
    logic [NN_W-1:0]  div_reg;
    logic [NN_W-1:0]  rem_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [5:0]       it_reg;

    logic [15:0] mean_reg [0:2];
    logic [22:0] cov_reg [0:5];
    logic        empty_reg;

    // input fields
    logic [11:0] in_col, in_row;
    assign in_col = s_tdata[11:0];
    assign in_row = s_tdata[23:12];

    // window test
    logic [CW-1:0] col_m, row_m, left_m, top_m, lim_w, lim_h;
    logic          in_win;
    always_comb begin
        col_m  = CW'(in_col) & CMASK;
        row_m  = CW'(in_row) & CMASK;
        left_m = CW'(win_left_reg) & CMASK;
        top_m  = CW'(win_top_reg) & CMASK;
        lim_w  = (CW'(win_width_reg) > SIDE_MAX) ? SIDE_MAX : CW'(win_width_reg);
        lim_h  = (CW'(win_height_reg) > SIDE_MAX) ? SIDE_MAX : CW'(win_height_reg);
        in_win = (col_m >= left_m) && (col_m < left_m + lim_w) &&
                 (row_m >= top_m) && (row_m < top_m + lim_h);
    end

    // shared multiplier operand select
    logic [31:0] mul_a;
    logic [23:0] mul_b;
    always_comb begin
        unique case (state_reg)
            ST_PMUL: begin
                mul_a = 32'(samp_reg[pair_x(k_reg)]);
                mul_b = 24'(samp_reg[pair_y(k_reg)]);
            end
            ST_FIN: begin
                mul_a = 32'(cnt_reg);
                mul_b = 24'(cnt_reg);
            end
            ST_CX: begin
                mul_a = sxy_reg[k_reg];
                mul_b = 24'(cnt_reg);
            end
            ST_CY: begin
                mul_a = 32'(ch_sum_reg[pair_x(k_reg)]);
                mul_b = ch_sum_reg[pair_y(k_reg)];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // full-width product of the shared multiplier
    logic [MUL_W-1:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // numerator and its magnitude
    logic [49:0] diff;
    logic [48:0] mag;
    always_comb begin
        diff = {1'b0, p1_reg} - {2'b0, mul_reg[47:0]};
        mag  = diff[49] ? 49'(-diff) : diff[48:0];
    end

    // one restoring divider step
    logic [NN_W:0]   rem_sh;
    logic            ge;
    logic [NN_W-1:0] rem_next;
    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        ge       = rem_sh >= {1'b0, div_reg};
        rem_next = ge ? NN_W'(rem_sh - {1'b0, div_reg}) : rem_sh[NN_W-1:0];
    end

    // quotient saturation
    logic [15:0] mean_sat;
    logic [22:0] cov_sat;
    logic        q_big;
    always_comb begin
        q_big    = dvd_reg > DVD_W'(COV_MAX);
        mean_sat = (dvd_reg > DVD_W'(MEAN_MAX)) ? MEAN_MAX : dvd_reg[15:0];
        if (neg_reg) begin
            if (k_reg == 3'd0 || k_reg == 3'd3 || k_reg == 3'd5) begin
                cov_sat = '0;
            end else begin
                cov_sat = q_big ? 23'(-COV_MAX) : 23'(-dvd_reg[22:0]);
            end
        end else begin
            cov_sat = q_big ? COV_MAX : dvd_reg[22:0];
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tuser   = empty_reg;
    assign m_tdata   = {1'b0, cov_reg[5][21:0], cov_reg[4], cov_reg[3][21:0], cov_reg[2],
                        cov_reg[1], cov_reg[0][21:0], mean_reg[2], mean_reg[1], mean_reg[0]};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg   <= WIN_LEFT_RST;
            win_top_reg    <= WIN_TOP_RST;
            win_width_reg  <= WIN_WIDTH_RST;
            win_height_reg <= WIN_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WIN_LEFT:   win_left_reg   <= cfg_data;
                REG_WIN_TOP:    win_top_reg    <= cfg_data;
                REG_WIN_WIDTH:  win_width_reg  <= cfg_data[8:0];
                REG_WIN_HEIGHT: win_height_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // shared multiplier, registered result
    always_ff @(posedge aclk) begin
        mul_reg <= mul_p;
    end

    // sequencer with accumulators and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            for (int i = 0; i < 3; i++) ch_sum_reg[i] <= '0;
            for (int i = 0; i < 6; i++) sxy_reg[i] <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            empty_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        samp_reg[0] <= s_tdata[31:24];
                        samp_reg[1] <= s_tdata[39:32];
                        samp_reg[2] <= s_tdata[47:40];
                        last_reg    <= s_tlast;
                        k_reg       <= '0;
                        if (in_win) begin
                            cnt_reg       <= cnt_reg + 1'b1;
                            ch_sum_reg[0] <= ch_sum_reg[0] + SUM_W'(s_tdata[31:24]);
                            ch_sum_reg[1] <= ch_sum_reg[1] + SUM_W'(s_tdata[39:32]);
                            ch_sum_reg[2] <= ch_sum_reg[2] + SUM_W'(s_tdata[47:40]);
                            state_reg     <= ST_PMUL;
                        end else if (s_tlast) begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_PMUL: state_reg <= ST_PACC;
                ST_PACC: begin
                    sxy_reg[k_reg] <= sxy_reg[k_reg] + mul_reg[PRD_W-1:0];
                    if (k_reg == 3'd5) begin
                        k_reg     <= '0;
                        state_reg <= last_reg ? ST_FIN : ST_IDLE;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_PMUL;
                    end
                end
                ST_FIN: begin
                    if (cnt_reg == '0) begin
                        for (int i = 0; i < 3; i++) mean_reg[i] <= '0;
                        for (int i = 0; i < 6; i++) cov_reg[i] <= '0;
                        empty_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        empty_reg <= 1'b0;
                        state_reg <= ST_DEN;
                    end
                end
                ST_DEN: begin
                    nn_reg       <= mul_reg[NN_W-1:0];
                    j_reg        <= '0;
                    cov_mode_reg <= 1'b0;
                    state_reg    <= ST_MLD;
                end
                ST_MLD: begin
                    div_reg   <= NN_W'(cnt_reg);
                    dvd_reg   <= DVD_W'({ch_sum_reg[j_reg], 8'd0});
                    rem_reg   <= '0;
                    it_reg    <= '0;
                    neg_reg   <= 1'b0;
                    state_reg <= ST_DIV;
                end
                ST_CX: state_reg <= ST_CY;
                ST_CY: begin
                    p1_reg    <= mul_reg[48:0];
                    state_reg <= ST_CSUB;
                end
                ST_CSUB: begin
                    neg_reg   <= diff[49];
                    dvd_reg   <= {mag, 8'd0};
                    div_reg   <= nn_reg;
                    rem_reg   <= '0;
                    it_reg    <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= rem_next;
                    dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
                    it_reg  <= it_reg + 1'b1;
                    if (it_reg == DIV_LAST) state_reg <= ST_DST;
                end
                ST_DST: begin
                    if (!cov_mode_reg) begin
                        mean_reg[j_reg] <= mean_sat;
                        if (j_reg == 2'd2) begin
                            cov_mode_reg <= 1'b1;
                            k_reg        <= '0;
                            state_reg    <= ST_CX;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_MLD;
                        end
                    end else begin
                        cov_reg[k_reg] <= cov_sat;
                        if (k_reg == 3'd5) begin
                            state_reg <= ST_OUT;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_CX;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        cnt_reg <= '0;
                        for (int i = 0; i < 3; i++) ch_sum_reg[i] <= '0;
                        for (int i = 0; i < 6; i++) sxy_reg[i] <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: verif/testbench.sv
// self-checking testbench of the windowed mean and covariance block
`timescale 1ns / 1ps

module testbench;
    import rwmc_pkg::*;

    localparam int    SETTLE_CYCLES = 600;
    localparam int    CYCLE_LIMIT   = 3000000;
    localparam int    WIDE          = 256;

    // result field layout in m_tdata, from the lowest bit up
    localparam int    FLD_LSB [9] = '{0, 16, 32, 48, 70, 93, 116, 138, 161};
    localparam int    FLD_W   [9] = '{16, 16, 16, 22, 23, 23, 22, 23, 22};
    localparam string FLD_NAME[9] = '{"mean_blue", "mean_green", "mean_red", "cov_bb",
                                      "cov_bg", "cov_br", "cov_gg", "cov_gr", "cov_rr"};

    typedef struct {
        logic [183:0] data;
        logic         empty;
    } stats_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [11:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;   // col_pos, row_pos, blue, green, red
    logic         s_tlast;   // frame_end
    logic         m_tvalid;
    logic         m_tready;
    logic [183:0] m_tdata;   // means, covariances, zero pad
    logic         m_tuser;   // window_empty

    // model copy of the window and accumulators
    int unsigned  win_l, win_t, win_w, win_h;
    longint       acc_n, acc_b, acc_g, acc_r;
    longint       acc_bb, acc_bg, acc_br, acc_gg, acc_gr, acc_rr;
    stats_t       pending_stats[$];
    int           errors;
    int           cycles;
    int           rd_wait;
    int           items_sent;

    rgb_window_mean_covariance dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run length guard
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint mean_calc(longint s, longint n);
        longint m;
        m = (s <<< 8) / n;
        return (m > longint'(MEAN_MAX)) ? longint'(MEAN_MAX) : m;
    endfunction

    function automatic longint cov_calc(longint sxy, longint sx, longint sy, longint n,
                                        bit is_var);
        longint c;
        c = ((n * sxy - sx * sy) * 256) / (n * n);
        if (c > longint'(COV_MAX)) c = longint'(COV_MAX);
        if (is_var && c < 0) c = 0;
        if (!is_var && c < -longint'(COV_MAX)) c = -longint'(COV_MAX);
        return c;
    endfunction

    function automatic void clear_sums();
        acc_n = 0; acc_b = 0; acc_g = 0; acc_r = 0;
        acc_bb = 0; acc_bg = 0; acc_br = 0; acc_gg = 0; acc_gr = 0; acc_rr = 0;
    endfunction

    // accumulate one accepted pixel and queue the frame statistics on frame end
    function automatic void predict_pixel(logic [11:0] col, logic [11:0] row,
                                          logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                          logic last);
        int unsigned ws, hs;
        stats_t      st;
        longint      v[9];
        ws = (win_w > WIDE) ? WIDE : win_w;
        hs = (win_h > WIDE) ? WIDE : win_h;
        if (col >= win_l && col < win_l + ws && row >= win_t && row < win_t + hs) begin
            acc_n  = (acc_n + 1) & 64'h1FFFF;
            acc_b  = (acc_b + b) & 64'hFFFFFF;
            acc_g  = (acc_g + g) & 64'hFFFFFF;
            acc_r  = (acc_r + r) & 64'hFFFFFF;
            acc_bb = (acc_bb + b * b) & 64'hFFFFFFFF;
            acc_bg = (acc_bg + b * g) & 64'hFFFFFFFF;
            acc_br = (acc_br + b * r) & 64'hFFFFFFFF;
            acc_gg = (acc_gg + g * g) & 64'hFFFFFFFF;
            acc_gr = (acc_gr + g * r) & 64'hFFFFFFFF;
            acc_rr = (acc_rr + r * r) & 64'hFFFFFFFF;
        end
        if (!last) return;
        st.data  = '0;
        st.empty = (acc_n == 0);
        if (!st.empty) begin
            v[0] = mean_calc(acc_b, acc_n);
            v[1] = mean_calc(acc_g, acc_n);
            v[2] = mean_calc(acc_r, acc_n);
            v[3] = cov_calc(acc_bb, acc_b, acc_b, acc_n, 1'b1);
            v[4] = cov_calc(acc_bg, acc_b, acc_g, acc_n, 1'b0);
            v[5] = cov_calc(acc_br, acc_b, acc_r, acc_n, 1'b0);
            v[6] = cov_calc(acc_gg, acc_g, acc_g, acc_n, 1'b1);
            v[7] = cov_calc(acc_gr, acc_g, acc_r, acc_n, 1'b0);
            v[8] = cov_calc(acc_rr, acc_r, acc_r, acc_n, 1'b1);
            for (int k = 0; k < 9; k++)
                st.data = st.data | ((184'(v[k]) & ((184'(1) << FLD_W[k]) - 1))
                                     << FLD_LSB[k]);
        end
        pending_stats.push_back(st);
        clear_sums();
    endfunction

    // result ready with random stalls
    always @(posedge aclk) begin
        int nxt;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rd_wait = 0;
        end else begin
            if (m_tvalid && m_tready) rd_wait = $urandom_range(0, 4);
            else if (rd_wait > 0) rd_wait = rd_wait - 1;
            nxt = (rd_wait == 0);
            m_tready <= nxt[0];
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge aclk) begin
        stats_t st;
        logic [22:0] ev, av;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, m_tdata);
                errors = errors + 1;
            end else begin
                st = pending_stats.pop_front();
                for (int k = 0; k < 9; k++) begin
                    ev = 23'((st.data >> FLD_LSB[k]) & ((184'(1) << FLD_W[k]) - 1));
                    av = 23'((m_tdata >> FLD_LSB[k]) & ((184'(1) << FLD_W[k]) - 1));
                    if (ev !== av) begin
                        $display("%0t: %s expected %h actual %h", $realtime, FLD_NAME[k],
                                 ev, av);
                        errors = errors + 1;
                    end
                end
                if (st.empty !== m_tuser) begin
                    $display("%0t: window_empty expected %b actual %b", $realtime,
                             st.empty, m_tuser);
                    errors = errors + 1;
                end
                if (m_tdata[183] !== 1'b0) begin
                    $display("%0t: pad bit expected 0 actual %b", $realtime, m_tdata[183]);
                    errors = errors + 1;
                end
            end
        end
    end

    // send one pixel word after a random gap
    task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [7:0] b,
                              logic [7:0] g, logic [7:0] r, logic last);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 7) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, g, b, row, col};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent = items_sent + 1;
        predict_pixel(col, row, b, g, r, last);
    endtask

    // let the block drain before touching the window
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WIN_LEFT:   win_l = val;
            REG_WIN_TOP:    win_t = val;
            REG_WIN_WIDTH:  win_w = val[8:0];
            REG_WIN_HEIGHT: win_h = val[8:0];
            default: ;
        endcase
    endtask

    task automatic set_window(int unsigned l, int unsigned t, int unsigned w,
                              int unsigned h);
        settle();
        write_reg(REG_WIN_LEFT, 12'(l));
        write_reg(REG_WIN_TOP, 12'(t));
        write_reg(REG_WIN_WIDTH, 12'(w));
        write_reg(REG_WIN_HEIGHT, 12'(h));
    endtask

    // reset window: corners, sample extremes, edges just outside
    task automatic test_reset_window();
        send_pixel(12'd515, 12'd189, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(12'd523, 12'd192, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(12'd524, 12'd190, 8'd7, 8'd9, 8'd11, 1'b0);
        send_pixel(12'd520, 12'd193, 8'd7, 8'd9, 8'd11, 1'b0);
        send_pixel(12'd514, 12'd188, 8'd7, 8'd9, 8'd11, 1'b0);
        send_pixel(12'd519, 12'd190, 8'd255, 8'd0, 8'd128, 1'b1);
        // empty frame
        send_pixel(12'd0, 12'd0, 8'd50, 8'd60, 8'd70, 1'b1);
        // single pixel frame
        send_pixel(12'd516, 12'd191, 8'd200, 8'd1, 8'd99, 1'b1);
    endtask

    // zero size, oversize, clipping at the coordinate edge, unknown index
    task automatic test_window_limits();
        set_window(0, 0, 0, 5);
        send_pixel(12'd0, 12'd0, 8'd1, 8'd2, 8'd3, 1'b1);
        set_window(0, 0, 5, 0);
        send_pixel(12'd0, 12'd0, 8'd1, 8'd2, 8'd3, 1'b1);
        set_window(0, 0, 511, 256);
        send_pixel(12'd0, 12'd0, 8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(12'd255, 12'd255, 8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(12'd256, 12'd10, 8'd9, 8'd9, 8'd9, 1'b1);
        set_window(4090, 4095, 256, 256);
        send_pixel(12'd4095, 12'd4095, 8'd10, 8'd250, 8'd30, 1'b0);
        send_pixel(12'd4090, 12'd4095, 8'd240, 8'd5, 8'd200, 1'b0);
        send_pixel(12'd0, 12'd0, 8'd3, 8'd3, 8'd3, 1'b1);
        settle();
        write_reg(8'd4, 12'hFFF);
        write_reg(8'hFF, 12'h000);
        send_pixel(12'd4092, 12'd4095, 8'd77, 8'd88, 8'd99, 1'b1);
    endtask

    // random windows, frames of mostly in-window pixels with noise
    task automatic test_random_frames();
        int unsigned w, h, len;
        logic [11:0] col, row;
        while (items_sent < 800) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 511) : $urandom_range(1, 16);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 511) : $urandom_range(1, 16);
            set_window($urandom_range(0, 4095), $urandom_range(0, 4095), w, h);
            for (int f = 0; f < 6; f++) begin
                len = $urandom_range(1, 30);
                for (int p = 0; p < len; p++) begin
                    if ($urandom_range(0, 9) < 7) begin
                        col = 12'(win_l + $urandom_range(0, w - 1));
                        row = 12'(win_t + $urandom_range(0, h - 1));
                    end else begin
                        col = 12'($urandom);
                        row = 12'($urandom);
                    end
                    send_pixel(col, row, 8'($urandom), 8'($urandom), 8'($urandom),
                               p == len - 1);
                end
            end
        end
    endtask

    // sequence of tests
    initial begin
        errors      = 0;
        items_sent  = 0;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        win_l = WIN_LEFT_RST;
        win_t = WIN_TOP_RST;
        win_w = WIN_WIDTH_RST;
        win_h = WIN_HEIGHT_RST;
        clear_sums();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_window();
        test_window_limits();
        test_random_frames();
        settle();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: rgb_window_mean_covariance.f
rtl/rwmc_pkg.sv
rtl/rgb_window_mean_covariance.sv
verif/testbench.sv
